### rtl/steering_switch_controller_unit_assert.svh
// Assertion macros shared by the steering switch controller modules
`ifndef STEERING_SWITCH_CONTROLLER_UNIT_ASSERT_SVH
`define STEERING_SWITCH_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssc_pkg.sv
// Types, codes and constants of the steering switch controller
package ssc_pkg;

    localparam int TIME_W         = 32;
    localparam int KIND_W         = 4;
    localparam int SPEED_IN_W     = 18;
    localparam int SPEED_OUT_W    = 18;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_SLOTS      = 9;
    localparam int SLOT_W         = 4;
    localparam int SPEED_BITS_DEF = 18;

    localparam logic [CFG_W-1:0] RST_CRUISE_DB = 16'd150;
    localparam logic [CFG_W-1:0] RST_BUTTON_DB = 16'd50;
    localparam logic [CFG_W-1:0] RST_PRE_DB    = 16'd200;
    localparam logic [CFG_W-1:0] RST_PRE_HOLD  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_STEP      = 16'd500;

    typedef enum logic [KIND_W-1:0] {
        K_HOLD      = 4'd0,
        K_UP        = 4'd1,
        K_DOWN      = 4'd2,
        K_HORN      = 4'd3,
        K_HAZARD    = 4'd4,
        K_LEFT      = 4'd5,
        K_RIGHT     = 4'd6,
        K_BRAKE     = 4'd7,
        K_REAR      = 4'd8,
        K_PRECHARGE = 4'd9
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_DB = 3'd0,
        CFG_BUTTON_DB = 3'd1,
        CFG_PRE_DB    = 3'd2,
        CFG_PRE_HOLD  = 3'd3,
        CFG_STEP      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_kind                 kind;
        logic [TIME_W-1:0]     time_ms;
        logic                  switch_level;
        logic [SPEED_IN_W-1:0] vehicle_speed;
        logic                  reversing;
    } t_evt;

    typedef struct packed {
        logic [CFG_W-1:0] cruise_db;
        logic [CFG_W-1:0] button_db;
        logic [CFG_W-1:0] pre_db;
        logic [CFG_W-1:0] pre_hold;
        logic [CFG_W-1:0] cruise_step;
    } t_cfg;

    typedef struct packed {
        logic                   cruise_on;
        logic [SPEED_OUT_W-1:0] cruise_speed;
        logic                   cruise_flash;
        logic                   hazards_on;
        logic                   left_on;
        logic                   right_on;
        logic                   horn_on;
        logic                   rear_view_on;
        logic                   brake_on;
        logic                   precharged;
        logic                   start_message;
    } t_res;

endpackage

### rtl/ssc_if.sv
// Channel interfaces: switch events, results and configuration writes
interface ssc_evt_if;
    logic                            valid;
    logic                            ready;
    logic [ssc_pkg::KIND_W-1:0]      kind;
    logic [ssc_pkg::TIME_W-1:0]      time_ms;
    logic                            switch_level;
    logic [ssc_pkg::SPEED_IN_W-1:0]  vehicle_speed;
    logic                            reversing;

    modport source (output valid, kind, time_ms, switch_level, vehicle_speed, reversing,
                    input ready);
    modport sink   (input valid, kind, time_ms, switch_level, vehicle_speed, reversing,
                    output ready);
endinterface

interface ssc_res_if;
    logic                             valid;
    logic                             ready;
    logic                             cruise_on;
    logic [ssc_pkg::SPEED_OUT_W-1:0]  cruise_speed;
    logic                             cruise_flash;
    logic                             hazards_on;
    logic                             left_on;
    logic                             right_on;
    logic                             horn_on;
    logic                             rear_view_on;
    logic                             brake_on;
    logic                             precharged;
    logic                             start_message;

    modport source (output valid, cruise_on, cruise_speed, cruise_flash, hazards_on, left_on,
                           right_on, horn_on, rear_view_on, brake_on, precharged,
                           start_message,
                    input ready);
    modport sink   (input valid, cruise_on, cruise_speed, cruise_flash, hazards_on, left_on,
                          right_on, horn_on, rear_view_on, brake_on, precharged,
                          start_message,
                    output ready);
endinterface

interface ssc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::CFG_IDX_W-1:0] index;
    logic [ssc_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ssc_cfg.sv
// Configuration register bank of the steering switch controller
module ssc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [ssc_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [ssc_pkg::CFG_W-1:0]     i_data,
    output ssc_pkg::t_cfg                 o_cfg
);

    ssc_pkg::t_cfg r_cfg;
    ssc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (ssc_pkg::t_cfg_idx'(i_index))
                ssc_pkg::CFG_CRUISE_DB: n_cfg.cruise_db   = i_data;
                ssc_pkg::CFG_BUTTON_DB: n_cfg.button_db   = i_data;
                ssc_pkg::CFG_PRE_DB:    n_cfg.pre_db      = i_data;
                ssc_pkg::CFG_PRE_HOLD:  n_cfg.pre_hold    = i_data;
                ssc_pkg::CFG_STEP:      n_cfg.cruise_step = i_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_db   <= ssc_pkg::RST_CRUISE_DB;
            r_cfg.button_db   <= ssc_pkg::RST_BUTTON_DB;
            r_cfg.pre_db      <= ssc_pkg::RST_PRE_DB;
            r_cfg.pre_hold    <= ssc_pkg::RST_PRE_HOLD;
            r_cfg.cruise_step <= ssc_pkg::RST_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ssc_core.sv
// Driver-control state and its update for one switch event
`include "steering_switch_controller_unit_assert.svh"

module ssc_core #(
    parameter int SPEED_BITS = ssc_pkg::SPEED_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  ssc_pkg::t_evt i_evt,
    input  ssc_pkg::t_cfg i_cfg,
    output ssc_pkg::t_res o_res
);

    localparam int SUM_W = ((SPEED_BITS > ssc_pkg::CFG_W) ? SPEED_BITS : ssc_pkg::CFG_W) + 1;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;
    localparam logic [ssc_pkg::SLOT_W-1:0] SLOT_REAR = 4'd7;
    localparam logic [ssc_pkg::SLOT_W-1:0] SLOT_PRE  = 4'd8;

    localparam int LT_HAZ   = 0;
    localparam int LT_LEFT  = 1;
    localparam int LT_RIGHT = 2;
    localparam int TG_HORN  = 0;
    localparam int TG_REAR  = 1;
    localparam int TG_BRAKE = 2;
    localparam int PR_HELD  = 0;
    localparam int PR_ON    = 1;
    localparam int PR_CAUGHT = 2;

    logic [ssc_pkg::TIME_W-1:0] r_last [ssc_pkg::NUM_SLOTS];
    logic                       r_cruise;
    logic [SPEED_BITS-1:0]      r_target;
    logic [2:0]                 r_light;
    logic [2:0]                 r_toggle;
    logic [2:0]                 r_pre;
    logic [ssc_pkg::TIME_W-1:0] r_press;

    logic                       n_cruise;
    logic [SPEED_BITS-1:0]      n_target;
    logic [2:0]                 n_light;
    logic [2:0]                 n_toggle;
    logic [2:0]                 n_pre;
    logic [ssc_pkg::TIME_W-1:0] n_press;

    logic                       w_has_slot;
    logic [ssc_pkg::SLOT_W-1:0] w_slot;
    logic [ssc_pkg::TIME_W-1:0] w_elapsed;
    logic [ssc_pkg::TIME_W-1:0] w_held;
    logic                       w_ge_cruise;
    logic                       w_gt_cruise;
    logic                       w_gt_button;
    logic                       w_ge_pre;
    logic [SUM_W-1:0]           w_up_sum;
    logic [SPEED_BITS-1:0]      w_up;
    logic [SPEED_BITS-1:0]      w_down;
    logic                       w_flash;
    logic                       w_start;

    always_comb begin
        w_has_slot = 1'b1;
        w_slot     = '0;
        unique case (i_evt.kind)
            ssc_pkg::K_HOLD, ssc_pkg::K_UP, ssc_pkg::K_DOWN, ssc_pkg::K_HORN,
            ssc_pkg::K_HAZARD, ssc_pkg::K_LEFT, ssc_pkg::K_RIGHT: begin
                w_slot = ssc_pkg::SLOT_W'(i_evt.kind);
            end
            ssc_pkg::K_REAR:      w_slot = SLOT_REAR;
            ssc_pkg::K_PRECHARGE: w_slot = SLOT_PRE;
            default:              w_has_slot = 1'b0;
        endcase
    end

    assign w_elapsed   = i_evt.time_ms - r_last[w_slot];
    assign w_held      = i_evt.time_ms - r_press;
    assign w_ge_cruise = w_elapsed >= ssc_pkg::TIME_W'(i_cfg.cruise_db);
    assign w_gt_cruise = w_elapsed >  ssc_pkg::TIME_W'(i_cfg.cruise_db);
    assign w_gt_button = w_elapsed >  ssc_pkg::TIME_W'(i_cfg.button_db);
    assign w_ge_pre    = w_elapsed >= ssc_pkg::TIME_W'(i_cfg.pre_db);

    assign w_up_sum = SUM_W'(r_target) + SUM_W'(i_cfg.cruise_step);
    assign w_up     = (w_up_sum >= SUM_W'(SPEED_MAX)) ? SPEED_MAX : w_up_sum[SPEED_BITS-1:0];
    assign w_down   = (SUM_W'(r_target) > SUM_W'(i_cfg.cruise_step))
                      ? r_target - SPEED_BITS'(i_cfg.cruise_step) : '0;

    always_comb begin
        n_cruise = r_cruise;
        n_target = r_target;
        n_light  = r_light;
        n_toggle = r_toggle;
        n_pre    = r_pre;
        n_press  = r_press;
        w_flash  = 1'b0;
        w_start  = 1'b0;
        unique case (i_evt.kind)
            ssc_pkg::K_HOLD: begin
                if (w_ge_cruise) begin
                    if (r_cruise) begin
                        n_cruise = 1'b0;
                        n_target = '0;
                    end else if (i_evt.reversing) begin
                        w_flash = 1'b1;
                    end else begin
                        n_cruise = 1'b1;
                        n_target = SPEED_BITS'(i_evt.vehicle_speed);
                    end
                end
            end
            ssc_pkg::K_UP: begin
                if (w_gt_cruise && r_cruise) begin
                    n_target = w_up;
                    w_flash  = 1'b1;
                end
            end
            ssc_pkg::K_DOWN: begin
                if (w_gt_cruise && r_cruise) begin
                    n_target = w_down;
                    w_flash  = 1'b1;
                end
            end
            ssc_pkg::K_HORN: begin
                if (w_gt_button) n_toggle[TG_HORN] = ~r_toggle[TG_HORN];
            end
            ssc_pkg::K_HAZARD: begin
                if (w_gt_button) n_light = {2'b00, ~r_light[LT_HAZ]};
            end
            ssc_pkg::K_LEFT: begin
                if (w_gt_button) begin
                    n_light[LT_HAZ]  = 1'b0;
                    n_light[LT_LEFT] = ~r_light[LT_LEFT];
                end
            end
            ssc_pkg::K_RIGHT: begin
                if (w_gt_button) begin
                    n_light[LT_HAZ]   = 1'b0;
                    n_light[LT_RIGHT] = ~r_light[LT_RIGHT];
                end
            end
            ssc_pkg::K_BRAKE: begin
                n_toggle[TG_BRAKE] = i_evt.switch_level;
                if (i_evt.switch_level) n_cruise = 1'b0;
            end
            ssc_pkg::K_REAR: begin
                if (w_gt_button) n_toggle[TG_REAR] = ~r_toggle[TG_REAR];
            end
            ssc_pkg::K_PRECHARGE: begin
                if (w_ge_pre) begin
                    if (r_pre[PR_HELD]) begin
                        n_pre[PR_HELD] = 1'b0;
                        if (w_held >= ssc_pkg::TIME_W'(i_cfg.pre_hold) && !r_pre[PR_CAUGHT]) begin
                            n_pre[PR_CAUGHT] = 1'b1;
                            n_pre[PR_ON]     = ~r_pre[PR_ON];
                            w_start          = 1'b1;
                        end
                    end else begin
                        n_pre[PR_HELD]   = 1'b1;
                        n_pre[PR_CAUGHT] = 1'b0;
                        n_press          = i_evt.time_ms;
                    end
                end
            end
            default: begin
                n_cruise = r_cruise;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssc_pkg::NUM_SLOTS; i++) begin
                r_last[i] <= '0;
            end
            r_cruise <= 1'b0;
            r_target <= '0;
            r_light  <= '0;
            r_toggle <= '0;
            r_pre    <= '0;
            r_press  <= '0;
        end else if (i_fire) begin
            if (w_has_slot) r_last[w_slot] <= i_evt.time_ms;
            r_cruise <= n_cruise;
            r_target <= n_target;
            r_light  <= n_light;
            r_toggle <= n_toggle;
            r_pre    <= n_pre;
            r_press  <= n_press;
        end
    end

    always_comb begin
        o_res.cruise_on     = n_cruise;
        o_res.cruise_speed  = ssc_pkg::SPEED_OUT_W'(n_target);
        o_res.cruise_flash  = w_flash;
        o_res.hazards_on    = n_light[LT_HAZ];
        o_res.left_on       = n_light[LT_LEFT];
        o_res.right_on      = n_light[LT_RIGHT];
        o_res.horn_on       = n_toggle[TG_HORN];
        o_res.rear_view_on  = n_toggle[TG_REAR];
        o_res.brake_on      = n_toggle[TG_BRAKE];
        o_res.precharged    = n_pre[PR_ON];
        o_res.start_message = w_start;
    end

    `SSC_ASSERT_NOW(a_lights_excl, r_light[LT_HAZ], !r_light[LT_LEFT] && !r_light[LT_RIGHT], "hazards on together with an indicator")
    `SSC_ASSERT_NEXT(a_brake_cancel, i_fire && i_evt.kind == ssc_pkg::K_BRAKE && i_evt.switch_level, !r_cruise && r_toggle[TG_BRAKE], "brake beat did not cancel cruise")
    `SSC_ASSERT_NOW(a_start_release, w_start, i_evt.kind == ssc_pkg::K_PRECHARGE && r_pre[PR_HELD] && !r_pre[PR_CAUGHT], "start pulse without a held precharge release")
    `SSC_ASSERT_NEXT(a_hold_off_zero, i_fire && i_evt.kind == ssc_pkg::K_HOLD && r_cruise && w_ge_cruise, !r_cruise && r_target == '0, "cruise hold off left a target")

endmodule

### rtl/steering_switch_controller_unit.sv
// Top level of the steering switch controller: event and result stages around the state core
//
// One switch-edge beat is taken per clock while the result is not stalled. On its way to the
// result beat, the event lands in an input register, the state core updates every flag,
// debounce time and the cruise target from that register, and the result lands in an output
// register. The sustained rate is one beat per cycle while the result is not stalled; a
// stalled result holds the output register and the input register in turn. Configuration
// writes are taken on every cycle; a register index beyond the five defined registers is
// dropped. Write configuration only while no event is in flight.
`include "steering_switch_controller_unit_assert.svh"

module steering_switch_controller_unit #(
    parameter int SPEED_BITS = ssc_pkg::SPEED_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_evt_if.sink   i_evt,
    ssc_cfg_if.sink   i_cfg,
    ssc_res_if.source o_res
);

    ssc_pkg::t_cfg w_cfg;
    ssc_pkg::t_res w_res;
    ssc_pkg::t_evt n_evt;
    ssc_pkg::t_evt r_evt;
    ssc_pkg::t_res r_res;
    logic          r_in_vld;
    logic          r_out_vld;
    logic          w_fire;
    logic          w_take;

    assign i_cfg.ready = 1'b1;

    ssc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    assign w_fire      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_evt.ready = !r_in_vld || w_fire;
    assign w_take      = i_evt.valid && i_evt.ready;

    always_comb begin
        n_evt.kind          = ssc_pkg::t_kind'(i_evt.kind);
        n_evt.time_ms       = i_evt.time_ms;
        n_evt.switch_level  = i_evt.switch_level;
        n_evt.vehicle_speed = i_evt.vehicle_speed;
        n_evt.reversing     = i_evt.reversing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_vld <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_evt <= n_evt;
    end

    ssc_core #(
        .SPEED_BITS (SPEED_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_evt   (r_evt),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_res <= w_res;
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.cruise_on     = r_res.cruise_on;
    assign o_res.cruise_speed  = r_res.cruise_speed;
    assign o_res.cruise_flash  = r_res.cruise_flash;
    assign o_res.hazards_on    = r_res.hazards_on;
    assign o_res.left_on       = r_res.left_on;
    assign o_res.right_on      = r_res.right_on;
    assign o_res.horn_on       = r_res.horn_on;
    assign o_res.rear_view_on  = r_res.rear_view_on;
    assign o_res.brake_on      = r_res.brake_on;
    assign o_res.precharged    = r_res.precharged;
    assign o_res.start_message = r_res.start_message;

    `SSC_ASSERT_NEXT(a_stall_keeps_evt, r_in_vld && !w_fire, r_in_vld, "stalled event beat dropped")
    `SSC_ASSERT_NOW(a_fire_has_room, w_fire, !r_out_vld || o_res.ready, "result register overwritten")
    `SSC_ASSERT_NEXT(a_fire_gives_result, w_fire, r_out_vld, "processed event left no result beat")

endmodule
